>>> rtl/cf_pkg.sv
// Shared types and constants for the celebrity finder.
`default_nettype none
package cf_pkg;

	localparam int ROW_W    = 3;
	localparam int BITS_W   = 8;
	localparam int COUNT_W  = 4;
	localparam int PERSON_W = 3;

	localparam int COUNT_MAX = (2 ** COUNT_W) - 1;
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [BITS_W-1:0] knows_bits;
		logic              last;
	} item_t;

	typedef struct packed {
		logic                found;
		logic [PERSON_W-1:0] person;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] person_count;
	} cfg_t;

	// top -> search engine
	typedef struct packed {
		logic               wr_en;
		logic [ROW_W-1:0]   wr_row;
		logic [BITS_W-1:0]  wr_bits;
		logic               start;
		logic [COUNT_W-1:0] n;
		logic               ack;
	} cf_ctl_t;

	// search engine -> top
	typedef struct packed {
		logic                busy;
		logic                done;
		logic                found;
		logic [PERSON_W-1:0] person;
	} cf_stat_t;

endpackage
`default_nettype wire

>>> rtl/cf_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
`default_nettype none
interface cf_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/celebrity_finder_unit.sv
// Top level of the celebrity finder: channels, count register, result register.
`default_nettype none
// Rows of the who-knows-whom matrix load one per cycle, while no search is
// running, into an internal row store. A transaction with last set also starts
// the search, and item.ready stays low until its result has been handed to the
// result register. The search runs on one sequencer and one bit-test unit fed by
// a single row-store read port: elimination reads and tests the candidate's row
// for each person after the first, verification the candidate's row and the
// column of each other person in turn, and a person count of zero goes straight
// to done. person_count above MAX_PEOPLE is treated as MAX_PEOPLE; rows at or
// above MAX_PEOPLE are dropped. A finished result sits in an output register, so
// rows keep loading while it waits to be taken.
module celebrity_finder_unit #(
	parameter int MAX_PEOPLE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	cf_stream_if.sink   item,
	cf_stream_if.sink   cfg,
	cf_stream_if.source result
);
	import cf_pkg::*;

	localparam int NMAX = (MAX_PEOPLE > COUNT_MAX) ? COUNT_MAX : MAX_PEOPLE;

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] n_sat;
	logic               res_valid_q;
	result_t            res_q;
	cf_ctl_t            ctl;
	cf_stat_t           stat;
	logic               item_acc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg.valid) begin
			count_q <= cfg.payload.person_count;
		end
	end

	assign n_sat = (int'(count_q) > NMAX) ? COUNT_W'(NMAX) : count_q;

	assign item.ready = ~stat.busy;
	assign item_acc   = item.valid & item.ready;

	always_comb begin
		ctl.wr_en   = item_acc;
		ctl.wr_row  = item.payload.row;
		ctl.wr_bits = item.payload.knows_bits;
		ctl.start   = item_acc & item.payload.last;
		ctl.n       = n_sat;
		ctl.ack     = stat.done & (~res_valid_q | result.ready);
	end

	cf_search #(
		.MAX_PEOPLE(MAX_PEOPLE)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.ack) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ack) begin
			res_q.found  <= stat.found;
			res_q.person <= stat.person;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule
`default_nettype wire

>>> rtl/cf_search.sv
// Row store and two-pass candidate search sequencer with one bit-test unit.
`default_nettype none
module cf_search #(
	parameter int MAX_PEOPLE = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cf_pkg::cf_ctl_t ctl,
	output cf_pkg::cf_stat_t stat
);
	import cf_pkg::*;

	localparam int DEPTH = (MAX_PEOPLE < BITS_W) ? MAX_PEOPLE : BITS_W;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_ELIM_RD   = 3'd1;
	localparam logic [2:0] S_ELIM_TST  = 3'd2;
	localparam logic [2:0] S_VROW_RD   = 3'd3;
	localparam logic [2:0] S_VROW_TST  = 3'd4;
	localparam logic [2:0] S_VCOL_RD   = 3'd5;
	localparam logic [2:0] S_VCOL_TST  = 3'd6;
	localparam logic [2:0] S_DONE      = 3'd7;

	logic [BITS_W-1:0]   mem [DEPTH];
	logic [BITS_W-1:0]   rd_data_q;
	logic [2:0]          state_q;
	logic [COUNT_W-1:0]  n_q;
	logic [COUNT_W-1:0]  idx_q;
	logic [PERSON_W-1:0] cand_q;
	logic                found_q;

	logic [COUNT_W-1:0]  cand_ext;
	logic [COUNT_W-1:0]  rd_sel;
	logic [COUNT_W-1:0]  tst_sel;
	logic                tst_bit;
	logic                wr_ok;

	assign cand_ext = {{(COUNT_W-PERSON_W){1'b0}}, cand_q};

	// candidate row is read in elimination and row check, person idx_q's row in column check
	assign rd_sel = (state_q == S_ELIM_RD || state_q == S_VROW_RD) ? cand_ext : idx_q;

	// shared bit-test unit: bits past the row width read as zero
	assign tst_sel = (state_q == S_VCOL_TST) ? cand_ext : idx_q;
	assign tst_bit = (int'(tst_sel) < BITS_W) ? rd_data_q[tst_sel[PERSON_W-1:0]] : 1'b0;

	assign wr_ok = ctl.wr_en && (int'(ctl.wr_row) < DEPTH);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[ctl.wr_row[IDX_W-1:0]] <= ctl.wr_bits;
		end
		rd_data_q <= mem[rd_sel[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			idx_q   <= '0;
			cand_q  <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						n_q     <= ctl.n;
						cand_q  <= '0;
						idx_q   <= COUNT_W'(1);
						found_q <= 1'b0;
						state_q <= (ctl.n == '0) ? S_DONE : S_ELIM_RD;
					end
				end
				S_ELIM_RD: begin
					if (idx_q == n_q) begin
						idx_q   <= '0;
						state_q <= S_VROW_RD;
					end else begin
						state_q <= S_ELIM_TST;
					end
				end
				S_ELIM_TST: begin
					// candidate knows idx: idx takes over
					if (tst_bit) begin
						cand_q <= idx_q[PERSON_W-1:0];
					end
					idx_q   <= idx_q + COUNT_W'(1);
					state_q <= S_ELIM_RD;
				end
				S_VROW_RD: begin
					if (idx_q == n_q) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else if (idx_q == cand_ext) begin
						idx_q <= idx_q + COUNT_W'(1);
					end else begin
						state_q <= S_VROW_TST;
					end
				end
				S_VROW_TST: begin
					state_q <= tst_bit ? S_DONE : S_VCOL_RD;
				end
				S_VCOL_RD: begin
					state_q <= S_VCOL_TST;
				end
				S_VCOL_TST: begin
					if (!tst_bit) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + COUNT_W'(1);
						state_q <= S_VROW_RD;
					end
				end
				S_DONE: begin
					if (ctl.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.busy   = (state_q != S_IDLE);
	assign stat.done   = (state_q == S_DONE);
	assign stat.found  = found_q;
	assign stat.person = found_q ? cand_q : '0;

endmodule
`default_nettype wire

>>> tb/celebrity_finder_checker.sv
// Checker for the celebrity finder: tracks the row store and count, predicts and compares results.
`default_nettype none
module celebrity_finder_checker (
	input  logic  clk,
	input  logic  arst_n,
	cf_stream_if  item,
	cf_stream_if  cfg,
	cf_stream_if  result,
	output int    errors,
	output int    pending,
	output int    searches
);
	timeunit 1ns;
	timeprecision 1ps;
	import cf_pkg::*;

	localparam int PEOPLE = 8;

	logic [BITS_W-1:0]  acq [PEOPLE];
	logic [COUNT_W-1:0] count_reg;
	result_t            answers_due [$];
	int                 err_count = 0;
	int                 result_count = 0;

	assign errors   = err_count;
	assign searches = result_count;
	assign pending  = answers_due.size();

	// running-candidate elimination, then a check of the candidate's row and column
	function automatic result_t find_celebrity();
		int      n;
		int      cand;
		logic    ok;
		result_t r;
		n = (count_reg > PEOPLE) ? PEOPLE : int'(count_reg);
		r = '0;
		if (n == 0)
			return r;
		cand = 0;
		for (int i = 1; i < n; i++)
			if (acq[cand][i])
				cand = i;
		ok = 1'b1;
		for (int i = 0; i < n; i++)
			if (i != cand && (acq[cand][i] || !acq[i][cand]))
				ok = 1'b0;
		r.found  = ok;
		r.person = ok ? PERSON_W'(cand) : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			count_reg = COUNT_RESET;
			answers_due.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				count_reg = cfg.payload.person_count;
			if (result.valid && result.ready) begin
				got = result.payload;
				result_count++;
				if (answers_due.size() == 0) begin
					$error("unexpected result: found %0b person %0d", got.found, got.person);
					err_count++;
				end else begin
					want = answers_due.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, got.found);
						err_count++;
					end
					if (got.person !== want.person) begin
						$error("person: expected %0d, got %0d", want.person, got.person);
						err_count++;
					end
				end
			end
			// the row of a last transaction is stored before the search reads the matrix
			if (item.valid && item.ready) begin
				acq[item.payload.row] = item.payload.knows_bits;
				if (item.payload.last)
					answers_due.push_back(find_celebrity());
			end
		end
	end

endmodule
`default_nettype wire

>>> tb/celebrity_finder_unit_test.sv
// Testbench top for the celebrity finder: clock, reset, stimulus and verdict.
`default_nettype none
module celebrity_finder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cf_pkg::*;

	localparam int PEOPLE     = 8;
	localparam int SETTLE_CYC = 64;
	localparam int ITEM_GOAL  = 650;

	logic clk;
	logic arst_n;

	cf_stream_if #(.payload_t(item_t))   item_ch ();
	cf_stream_if #(.payload_t(cfg_t))    cfg_ch ();
	cf_stream_if #(.payload_t(result_t)) result_ch ();

	int errors;
	int pending;
	int searches;

	logic [BITS_W-1:0]  loaded_rows [PEOPLE];
	logic [COUNT_W-1:0] cur_count;
	bit                 calm;
	int                 rows_sent;
	int                 settings_used;

	celebrity_finder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	celebrity_finder_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.cfg      (cfg_ch),
		.result   (result_ch),
		.errors   (errors),
		.pending  (pending),
		.searches (searches)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Verification failed");
		$finish;
	end

	function automatic int draw_pause();
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	// result side: a fresh stall before each transaction
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		stall = draw_pause();
		forever begin
			@(negedge clk);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				stall = draw_pause();
		end
	end

	task automatic send_row(input logic [ROW_W-1:0] r, input logic [BITS_W-1:0] b,
		input logic l);
		item_t it;
		int    gap;
		gap = draw_pause();
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		it.row        = r;
		it.knows_bits = b;
		it.last       = l;
		@(negedge clk);
		item_ch.valid   <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
		loaded_rows[r] = b;
		rows_sent++;
	endtask

	// drain outstanding searches, then give the engine time to go idle
	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic set_count(input logic [COUNT_W-1:0] v);
		cfg_t c;
		settle();
		c.person_count = v;
		@(negedge clk);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= c;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cur_count = v;
		settings_used++;
		calm = ($urandom_range(0, 3) == 0);
	endtask

	// Build a new matrix (optionally with a planted celebrity, optionally spoiled by
	// one bit), send changed rows (or one random row) shuffled, last on the final one.
	task automatic send_party(input bit want_celeb, input bit spoil);
		logic [BITS_W-1:0] plan [PEOPLE];
		int                n;
		int                c;
		int                o;
		int                k;
		int                tmp;
		int                order [$];
		n = (cur_count > PEOPLE) ? PEOPLE : int'(cur_count);
		for (int r = 0; r < PEOPLE; r++)
			plan[r] = ($urandom_range(0, 2) == 0) ? BITS_W'($urandom) : loaded_rows[r];
		if (want_celeb && n > 0) begin
			c = $urandom_range(0, n - 1);
			for (int i = 0; i < n; i++)
				if (i != c) begin
					plan[c][i] = 1'b0;
					plan[i][c] = 1'b1;
				end
			if (spoil && n >= 2) begin
				o = $urandom_range(0, n - 2);
				if (o >= c)
					o++;
				if ($urandom_range(0, 1))
					plan[c][o] = 1'b1;
				else
					plan[o][c] = 1'b0;
			end
		end
		for (int r = 0; r < PEOPLE; r++)
			if (plan[r] != loaded_rows[r])
				order.push_back(r);
		if (order.size() == 0)
			order.push_back($urandom_range(0, PEOPLE - 1));
		for (int i = order.size() - 1; i > 0; i--) begin
			k        = $urandom_range(0, i);
			tmp      = order[i];
			order[i] = order[k];
			order[k] = tmp;
		end
		for (int i = 0; i < order.size(); i++)
			send_row(ROW_W'(order[i]), plan[order[i]], i == order.size() - 1);
	endtask

	initial begin
		logic [COUNT_W-1:0] seeded [7];
		int                 phase;
		int                 phase_end;
		int                 sel;
		seeded = '{4'd8, 4'd3, 4'd9, 4'd15, 4'd0, 4'd1, 4'd6};
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.payload  = '0;
		cur_count       = COUNT_RESET;
		calm            = 1'b0;
		rows_sent       = 0;
		settings_used   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// person 3 known by all and knowing nobody; diagonal bits set everywhere
		for (int r = 0; r < PEOPLE; r++)
			send_row(ROW_W'(r), (r == 3) ? 8'h08 : 8'hFF, r == PEOPLE - 1);
		send_row(3'd3, 8'hFF, 1'b1);	// the celebrity now knows everyone
		send_row(3'd3, 8'h00, 1'b1);
		send_row(3'd5, 8'h00, 1'b1);	// one person no longer knows the celebrity
		// celebrity at person 0, candidate never moves
		send_row(3'd0, 8'h01, 1'b0);
		send_row(3'd3, 8'hFF, 1'b0);
		send_row(3'd5, 8'hFF, 1'b1);
		// celebrity at the last person
		send_row(3'd0, 8'h80, 1'b0);
		send_row(3'd7, 8'h00, 1'b1);
		set_count(4'd0);
		send_row(3'd2, 8'hFF, 1'b1);
		set_count(4'd1);	// single person
		send_row(3'd4, 8'h00, 1'b1);
		set_count(4'd15);	// saturates to the full party
		send_row(3'd6, 8'hFF, 1'b1);
		set_count(4'd2);
		send_row(3'd1, 8'h00, 1'b1);

		phase = 0;
		while (rows_sent < ITEM_GOAL) begin
			set_count((phase < 7) ? seeded[phase] : COUNT_W'($urandom_range(0, 15)));
			phase_end = rows_sent + 60;
			while (rows_sent < phase_end) begin
				sel = $urandom_range(0, 19);
				if (sel < 13)
					send_party($urandom_range(0, 3) != 0, 1'b0);
				else if (sel < 16)
					send_party(1'b1, 1'b1);
				else
					send_row(ROW_W'($urandom), BITS_W'($urandom), $urandom_range(0, 3) == 0);
			end
			phase++;
		end

		settle();
		$display("%0d rows loaded, %0d searches checked", rows_sent, searches);
		$display("%0d person-count writes, from 0 through 15", settings_used);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
